/* rtl/bounded_lifo_stack_core_assert.svh */
// ============================================================================
// bounded_lifo_stack_core_assert.svh
// Assertion macros shared by the stack core RTL.
// ============================================================================
`ifndef BOUNDED_LIFO_STACK_CORE_ASSERT_SVH
`define BOUNDED_LIFO_STACK_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define BLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define BLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition never holds
`define BLS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/bls_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bls_pkg
// Field widths, operation and status codes, and controller states of the
// bounded LIFO stack core.
// ============================================================================
package bls_pkg;

    // Beat field widths
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP
    } state_t;

endpackage

/* rtl/bls_cmd_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// bls_cmd_if
// Command channel: one stack operation per beat.
// ============================================================================
interface bls_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [bls_pkg::FUNC_W-1:0]         func;
    logic signed [bls_pkg::VALUE_W-1:0] value;
    logic [bls_pkg::POS_W-1:0]          position;

    modport source (output valid, output func, output value, output position,
                    input ready);
    modport sink   (input valid, input func, input value, input position,
                    output ready);
endinterface

/* rtl/bls_rsp_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// bls_rsp_if
// Response channel: one result per command beat.
// ============================================================================
interface bls_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [bls_pkg::DATA_W-1:0] data;
    logic [bls_pkg::STATUS_W-1:0]      status;
    logic [bls_pkg::FILL_W-1:0]        fill_count;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output data, output status, output fill_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input data, input status, input fill_count,
                    input is_empty, input is_full, output ready);
endinterface

/* rtl/bls_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// bls_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bounded_lifo_stack_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// bounded_lifo_stack_core
// Fixed-depth LIFO stack of signed words with push, pop, peek and change.
// ============================================================================
// After reset the core sweeps the slot RAM to zero, one slot per cycle, and
// takes no command beat during that sweep. After that the accept cycle of a
// command issues the RAM read (top slot for pop, the addressed slot for peek),
// and the write-back state then writes back and loads the result into the
// output register. The single RAM port pair and its registered read data keep
// the core to one operation at a time: no beat is taken during write-back. A
// new command is taken while the previous result still waits in the output
// register; the write-back cycle then holds until that result is taken.
// ============================================================================
module bounded_lifo_stack_core #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bls_cmd_if.sink   cmd,
    bls_rsp_if.source rsp
);

    import bls_pkg::*;

`include "bounded_lifo_stack_core_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L   = LW'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [LW-1:0]     level_reg, level_next;
    logic              out_valid_reg, out_valid_next;

    // Command hold
    op_t               op_reg;
    logic [WORD_BITS-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;

    // Result register
    logic signed [DATA_W-1:0] data_reg;
    status_t           status_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              empty_reg;
    logic              full_reg;

    // RAM ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                     cmd_take;
    logic                     load_out;
    logic                     pos_ok;
    logic signed [DATA_W-1:0] res_data;
    status_t                  res_status;

    bls_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_take = cmd.valid && cmd.ready;
    assign pos_ok   = (int'(pos_reg) < DEPTH);

    // Next state, RAM access and result
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        level_next     = level_reg;
        cmd.ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        load_out       = 1'b0;
        res_data       = '0;
        res_status     = STATUS_OK;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one slot per cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Take a beat and issue its slot read
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    ram_re = 1'b1;
                    if (op_t'(cmd.func) == OP_POP)
                    begin
                        ram_raddr = AW'(level_reg - 1'b1);
                    end
                    else
                    begin
                        ram_raddr = AW'(cmd.position);
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // Write back and load the result once the output slot frees
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (level_reg == DEPTH_L)
                            begin
                                res_status = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(level_reg);
                                ram_wdata  = value_reg;
                                level_next = level_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (level_reg == '0)
                            begin
                                res_status = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                res_data   = DATA_W'($signed(ram_rdata));
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(level_reg - 1'b1);
                                level_next = level_reg - 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (level_reg == '0)
                            begin
                                res_status = STATUS_UNDERFLOW;
                            end
                            else if (pos_ok)
                            begin
                                res_data = DATA_W'($signed(ram_rdata));
                            end
                        end
                        OP_CHANGE:
                        begin
                            if (pos_ok)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(pos_reg);
                                ram_wdata = value_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // Hold the result until it is taken
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg    <= op_t'(cmd.func);
            value_reg <= WORD_BITS'(cmd.value);
            pos_reg   <= cmd.position;
        end
        if (load_out)
        begin
            data_reg   <= res_data;
            status_reg <= res_status;
            fill_reg   <= FILL_W'(level_next);
            empty_reg  <= (level_next == '0);
            full_reg   <= (level_next == DEPTH_L);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data       = data_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = fill_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;

    // Read and write-back never share a cycle, so no forwarding is needed
    `BLS_ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, ram_we && ram_re, "RAM read and write overlap")
    `BLS_ASSERT_IMPL(a_level_bound, clk, rst_n, 1'b1, level_reg <= DEPTH_L, "stack level beyond depth")
    `BLS_ASSERT_NEXT(a_accept_resp, clk, rst_n, cmd_take, state_reg == ST_RESP, "accepted beat not in write-back")
    `BLS_ASSERT_IMPL(a_overflow_full, clk, rst_n, rsp.valid && (status_reg == STATUS_OVERFLOW), full_reg, "overflow on a stack not full")

endmodule

/* test/bounded_lifo_stack_core_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// bounded_lifo_stack_core_checker
// Watches the command and response channels of the stack core. It keeps a
// mirror of the slot RAM and the fill level, and it predicts one response
// for every accepted command beat. Each response beat is compared with the
// oldest prediction.
// ============================================================================
module bounded_lifo_stack_core_checker #(
    parameter int DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    bls_cmd_if   cmd,
    bls_rsp_if   rsp,
    output int   error_count,
    output int   pending_count
);
    import bls_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        logic                     is_full;
    } stack_rsp_t;

    // Mirror of the stack contents
    logic signed [VALUE_W-1:0] slot_mirror [DEPTH];
    int                        depth_used;

    stack_rsp_t pending_rsp_q [$];
    stack_rsp_t got_rsp;
    stack_rsp_t want_rsp;

    // Apply one operation to the mirror and return the response it causes
    function automatic stack_rsp_t stack_apply(input op_t op,
                                               input logic signed [VALUE_W-1:0] value,
                                               input logic [POS_W-1:0] position);
        stack_rsp_t r;
        r.data   = '0;
        r.status = STATUS_OK;
        case (op)
            OP_PUSH:
            begin
                if (depth_used >= DEPTH)
                    r.status = STATUS_OVERFLOW;
                else
                begin
                    slot_mirror[depth_used] = value;
                    depth_used++;
                end
            end
            OP_POP:
            begin
                if (depth_used == 0)
                    r.status = STATUS_UNDERFLOW;
                else
                begin
                    depth_used--;
                    r.data = slot_mirror[depth_used];
                    slot_mirror[depth_used] = '0;
                end
            end
            OP_PEEK:
            begin
                // Peek reads any slot, even above the level, once not empty
                if (depth_used == 0)
                    r.status = STATUS_UNDERFLOW;
                else if (position < DEPTH)
                    r.data = slot_mirror[position];
            end
            default:
            begin
                // Change writes any slot and leaves the level alone
                if (position < DEPTH)
                    slot_mirror[position] = value;
            end
        endcase
        r.fill_count = depth_used[FILL_W-1:0];
        r.is_empty   = (depth_used == 0);
        r.is_full    = (depth_used >= DEPTH);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slot_mirror[i] = '0;
            depth_used = 0;
            pending_rsp_q.delete();
            error_count = 0;
            pending_count = 0;
        end
        else
        begin
            // Check the response beat against the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                got_rsp = {rsp.data, rsp.status, rsp.fill_count, rsp.is_empty, rsp.is_full};
                if (pending_rsp_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: response beat with none expected: data=%0d status=%0d",
                             $time, got_rsp.data, got_rsp.status);
                end
                else
                begin
                    want_rsp = pending_rsp_q.pop_front();
                    pending_count--;
                    if (got_rsp !== want_rsp)
                    begin
                        error_count++;
                        $display("%0t: response mismatch: expected data=%0d status=%0d",
                                 $time, want_rsp.data, want_rsp.status,
                                 " fill=%0d empty=%0b full=%0b",
                                 want_rsp.fill_count, want_rsp.is_empty, want_rsp.is_full);
                        $display("%0t:                    actual data=%0d status=%0d",
                                 $time, got_rsp.data, got_rsp.status,
                                 " fill=%0d empty=%0b full=%0b",
                                 got_rsp.fill_count, got_rsp.is_empty, got_rsp.is_full);
                    end
                end
            end

            // Predict the response of an accepted command beat
            if (cmd.valid && cmd.ready)
            begin
                pending_rsp_q.push_back(stack_apply(op_t'(cmd.func), cmd.value, cmd.position));
                pending_count++;
            end
        end
    end

endmodule

/* test/bounded_lifo_stack_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// bounded_lifo_stack_core_test
// Drives the stack core with a directed sequence over empty, full and
// out-of-level cases, then with random phases that push the level up and
// down. The sender works in bursts, the receiver stalls on its own pattern
// and once holds off long enough to back up the command channel.
// ============================================================================
module bounded_lifo_stack_core_test;
    import bls_pkg::*;

    localparam int DEPTH        = 8;
    localparam int WORD_BITS    = 32;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_START   = 1200;
    localparam int HOLD_LEN     = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   burst_left = 0;

    bls_cmd_if cmd();
    bls_rsp_if rsp();

    bounded_lifo_stack_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    bounded_lifo_stack_core_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Give up after a generous number of cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Word with a bias toward the extremes
    function automatic logic signed [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one command beat, idling between bursts, and hold until taken
    task automatic send_beat(input op_t op, input logic signed [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] position);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        cmd.valid    <= 1'b1;
        cmd.func     <= op;
        cmd.value    <= value;
        cmd.position <= position;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    // Walk the empty, above-level and full corners
    task automatic run_directed();
        send_beat(OP_POP, 32'h1111_1111, 3'd0);
        send_beat(OP_CHANGE, 32'h7FFF_FFFF, 3'd5);
        send_beat(OP_PEEK, '0, 3'd5);
        send_beat(OP_PUSH, 32'h7FFF_FFFF, 3'd7);
        send_beat(OP_PUSH, 32'h8000_0000, 3'd0);
        send_beat(OP_PEEK, '0, 3'd7);
        send_beat(OP_PEEK, '0, 3'd5);
        send_beat(OP_CHANGE, '1, 3'd7);
        send_beat(OP_PEEK, '0, 3'd7);
        send_beat(OP_PUSH, '0, 3'd0);
        send_beat(OP_PUSH, '1, 3'd0);
        send_beat(OP_PUSH, 32'h5555_5555, 3'd2);
        send_beat(OP_PUSH, 32'hAAAA_AAAA, 3'd5);
        send_beat(OP_PUSH, 32'd1, 3'd0);
        send_beat(OP_PUSH, 32'h1234_5678, 3'd0);
        send_beat(OP_PUSH, 32'd42, 3'd0);
        send_beat(OP_PEEK, '0, 3'd0);
        send_beat(OP_CHANGE, 32'h8000_0000, 3'd0);
        send_beat(OP_POP, '0, 3'd0);
        send_beat(OP_PEEK, '0, 3'd7);
        for (int i = 0; i < 7; i++)
            send_beat(OP_POP, '0, 3'(i));
    endtask

    // Random phases, each biased to fill, drain or churn the stack
    task automatic run_random();
        int done;
        int phase_len;
        int push_w;
        int pop_w;
        int peek_w;
        int r;
        op_t op;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:
                begin
                    push_w = 65;
                    pop_w  = 15;
                end
                1:
                begin
                    push_w = 15;
                    pop_w  = 65;
                end
                default:
                begin
                    push_w = 30;
                    pop_w  = 30;
                end
            endcase
            peek_w = $urandom_range(5, 15);
            for (int i = 0; i < phase_len && done < RANDOM_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_w)
                    op = OP_PUSH;
                else if (r < push_w + pop_w)
                    op = OP_POP;
                else if (r < push_w + pop_w + peek_w)
                    op = OP_PEEK;
                else
                    op = OP_CHANGE;
                send_beat(op, rand_word(), POS_W'($urandom_range(0, 7)));
                done++;
            end
        end
    endtask

    // Receiver: stall on a changing pattern, with one long hold-off
    initial
    begin
        int          cyc;
        int          mode;
        logic [15:0] pattern;
        cyc = 0;
        mode = 0;
        pattern = '1;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
            begin
                mode = $urandom_range(0, 3);
                pattern = 16'($urandom);
            end
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                rsp.ready <= 1'b0;
            else
            begin
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= pattern[cyc % 16];
                    2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Sender and verdict
    initial
    begin
        rst_n        <= 1'b0;
        cmd.valid    <= 1'b0;
        cmd.func     <= OP_PUSH;
        cmd.value    <= '0;
        cmd.position <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        cmd.valid <= 1'b0;

        // Drain outstanding responses, then let the pipeline settle
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
